/* hdl/utf8_word_vowel_counter_macros.svh */
// Assertion helpers for the word/vowel counter checker.
`ifndef UTF8_WORD_VOWEL_COUNTER_MACROS_SVH
`define UTF8_WORD_VOWEL_COUNTER_MACROS_SVH

// Property checked only while out of reset.
`define UWVC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("uwvc assertion failed");

// Property checked on every edge, reset included.
`define UWVC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("uwvc assertion failed");

`endif

/* hdl/uwvc_pkg.sv */
package uwvc_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int MAX_COUNT_W     = 64;
    localparam int OUT_W           = 32;
    localparam int CODE_W          = 32;
    localparam int BYTE_W          = 8;
    localparam int PEND_W          = 3;
    localparam int NUM_FAM         = 6;

    localparam logic [CODE_W-1:0] CP_APOS    = CODE_W'(32'h27);
    localparam logic [CODE_W-1:0] FOLD_BASE  = CODE_W'(32'hE0);
    localparam logic [CODE_W-1:0] FOLD_OFS   = CODE_W'(32'h20);
    localparam logic [CODE_W-1:0] QUOTE_LEFT = CODE_W'(32'h1FF8);
    localparam logic [CODE_W-1:0] QUOTE_RGHT = CODE_W'(32'h1FF9);

    typedef enum logic {
        CMD_DATA = 1'b0,
        CMD_END  = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        FAM_A,
        FAM_E,
        FAM_I,
        FAM_O,
        FAM_U,
        FAM_Y,
        FAM_NONE
    } t_family;

    // Decoded code point handed from the decoder to the counter stage.
    typedef struct packed {
        logic              valid;
        logic              last;
        logic [CODE_W-1:0] code;
    } t_cp;

    typedef struct packed {
        logic [OUT_W-1:0] word_count;
        logic [OUT_W-1:0] a_count;
        logic [OUT_W-1:0] e_count;
        logic [OUT_W-1:0] i_count;
        logic [OUT_W-1:0] o_count;
        logic [OUT_W-1:0] u_count;
        logic [OUT_W-1:0] y_count;
    } t_result;

    // Codes >= 0xE0 drop 0x20 (Latin-1 lower to upper); curly quotes map to 0x27.
    function automatic logic [CODE_W-1:0] fold_code(input logic [CODE_W-1:0] c);
        logic [CODE_W-1:0] f;
        f = (c >= FOLD_BASE) ? c - FOLD_OFS : c;
        if (f == QUOTE_LEFT || f == QUOTE_RGHT) begin
            f = CP_APOS;
        end
        return f;
    endfunction

    function automatic logic in_range(input logic [CODE_W-1:0] c,
                                      input logic [7:0] lo, input logic [7:0] hi);
        return (c >= CODE_W'(lo)) && (c <= CODE_W'(hi));
    endfunction

    // Word characters other than the apostrophe.
    function automatic logic is_word_base(input logic [CODE_W-1:0] c);
        return in_range(c, 8'h41, 8'h5A) || in_range(c, 8'h61, 8'h7A) ||
               c == CODE_W'(8'hC7) || c == CODE_W'(8'h5F) ||
               in_range(c, 8'hC0, 8'hC3) || in_range(c, 8'hC8, 8'hCA) ||
               in_range(c, 8'hCC, 8'hCD) || in_range(c, 8'hD2, 8'hD5) ||
               in_range(c, 8'hD9, 8'hDA) || in_range(c, 8'h30, 8'h39);
    endfunction

    function automatic t_family vowel_family(input logic [CODE_W-1:0] c);
        t_family f;
        if (c == CODE_W'(8'h41) || c == CODE_W'(8'h61) || in_range(c, 8'hC0, 8'hC3)) begin
            f = FAM_A;
        end else if (c == CODE_W'(8'h45) || c == CODE_W'(8'h65) ||
                     in_range(c, 8'hC8, 8'hCA)) begin
            f = FAM_E;
        end else if (c == CODE_W'(8'h49) || c == CODE_W'(8'h69) ||
                     in_range(c, 8'hCC, 8'hCD)) begin
            f = FAM_I;
        end else if (c == CODE_W'(8'h4F) || c == CODE_W'(8'h6F) ||
                     in_range(c, 8'hD2, 8'hD5)) begin
            f = FAM_O;
        end else if (c == CODE_W'(8'h55) || c == CODE_W'(8'h75) ||
                     in_range(c, 8'hD9, 8'hDA)) begin
            f = FAM_U;
        end else if (c == CODE_W'(8'h79) || c == CODE_W'(8'h59)) begin
            f = FAM_Y;
        end else begin
            f = FAM_NONE;
        end
        return f;
    endfunction

endpackage

/* hdl/uwvc_ifs.sv */
interface uwvc_in_if;
    import uwvc_pkg::*;

    logic              valid;
    logic              ready;
    logic              command;
    logic [BYTE_W-1:0] data_byte;

    modport source(output valid, command, data_byte, input ready);
    modport sink(input valid, command, data_byte, output ready);
endinterface

interface uwvc_out_if;
    import uwvc_pkg::*;

    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] word_count;
    logic [OUT_W-1:0] a_count;
    logic [OUT_W-1:0] e_count;
    logic [OUT_W-1:0] i_count;
    logic [OUT_W-1:0] o_count;
    logic [OUT_W-1:0] u_count;
    logic [OUT_W-1:0] y_count;

    modport source(output valid, word_count, a_count, e_count, i_count, o_count,
                   u_count, y_count, input ready);
    modport sink(input valid, word_count, a_count, e_count, i_count, o_count,
                 u_count, y_count, output ready);
endinterface

/* hdl/uwvc_decode.sv */
module uwvc_decode (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_command,
    input  logic [uwvc_pkg::BYTE_W-1:0] i_data_byte,
    output uwvc_pkg::t_cp             o_cp,
    input  logic                      i_cp_ready
);
    import uwvc_pkg::*;

    logic              r_in_valid;
    t_cmd              r_in_cmd;
    logic [BYTE_W-1:0] r_in_byte;

    logic [PEND_W-1:0] r_pend, n_pend;
    logic [CODE_W-1:0] r_acc, n_acc;

    logic              r_cp_valid;
    logic              r_cp_last;
    logic [CODE_W-1:0] r_cp_code;

    logic              slot;
    logic              step;
    logic              emit;
    logic [CODE_W-1:0] emit_code;
    logic [CODE_W-1:0] shifted;

    assign slot    = !r_cp_valid || i_cp_ready;
    assign step    = r_in_valid && slot;
    assign o_ready = !r_in_valid || slot;
    assign shifted = {r_acc[CODE_W-7:0], r_in_byte[5:0]};

    always_comb begin
        n_pend    = r_pend;
        n_acc     = r_acc;
        emit      = 1'b0;
        emit_code = shifted;
        if (r_in_cmd == CMD_END) begin
            n_pend = '0;
            n_acc  = '0;
            emit   = 1'b1;
        end else if (r_pend != '0) begin
            // any byte is a continuation while a sequence is open
            n_acc  = shifted;
            n_pend = r_pend - PEND_W'(1);
            emit   = (r_pend == PEND_W'(1));
        end else begin
            unique casez (r_in_byte)
                8'b0???????: begin
                    emit      = 1'b1;
                    emit_code = CODE_W'(r_in_byte);
                end
                8'b10??????: begin
                    // lone continuation
                    emit      = 1'b1;
                    emit_code = CODE_W'(r_in_byte[5:0]);
                end
                8'b110?????: begin
                    n_pend = PEND_W'(1);
                    n_acc  = CODE_W'(r_in_byte[4:0]);
                end
                8'b1110????: begin
                    n_pend = PEND_W'(2);
                    n_acc  = CODE_W'(r_in_byte[3:0]);
                end
                8'b11110???: begin
                    n_pend = PEND_W'(3);
                    n_acc  = CODE_W'(r_in_byte[2:0]);
                end
                8'b111110??: begin
                    n_pend = PEND_W'(4);
                    n_acc  = CODE_W'(r_in_byte[1:0]);
                end
                8'b1111110?: begin
                    n_pend = PEND_W'(5);
                    n_acc  = CODE_W'(r_in_byte[0]);
                end
                8'b11111110: begin
                    n_pend = PEND_W'(6);
                    n_acc  = '0;
                end
                default: begin
                    n_pend = PEND_W'(7);
                    n_acc  = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_pend     <= '0;
            r_acc      <= '0;
            r_cp_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (step) begin
                r_pend <= n_pend;
                r_acc  <= n_acc;
            end
            if (slot) begin
                r_cp_valid <= step && emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_cmd  <= t_cmd'(i_command);
            r_in_byte <= i_data_byte;
        end
        if (slot) begin
            r_cp_last <= (r_in_cmd == CMD_END);
            r_cp_code <= emit_code;
        end
    end

    assign o_cp = '{valid: r_cp_valid, last: r_cp_last, code: r_cp_code};

endmodule

/* hdl/uwvc_count.sv */
module uwvc_count #(
    parameter int COUNT_WIDTH = uwvc_pkg::COUNT_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  uwvc_pkg::t_cp     i_cp,
    output logic              o_cp_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output uwvc_pkg::t_result o_res
);
    import uwvc_pkg::*;

    logic [COUNT_WIDTH-1:0] r_words, n_words;
    logic [COUNT_WIDTH-1:0] r_vtot [NUM_FAM];
    logic [COUNT_WIDTH-1:0] n_vtot [NUM_FAM];
    logic [NUM_FAM-1:0]     r_seen, n_seen;
    logic                   r_in_word, n_in_word;

    logic                   r_out_valid;
    t_result                r_res;

    logic                   take;
    logic [CODE_W-1:0]      code_f;
    logic                   is_word;
    t_family                fam;
    logic [NUM_FAM-1:0]     fam_hot;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (&v) ? v : v + COUNT_WIDTH'(1);
    endfunction

    function automatic logic [OUT_W-1:0] to_out(input logic [COUNT_WIDTH-1:0] v);
        logic [MAX_COUNT_W-1:0] wide;
        wide = MAX_COUNT_W'(v);
        return wide[OUT_W-1:0];
    endfunction

    // an end word waits only while an unread result sits in the output register
    assign o_cp_ready = !i_cp.last || !r_out_valid || i_ready;
    assign take       = i_cp.valid && o_cp_ready;

    assign code_f  = fold_code(i_cp.code);
    assign is_word = (code_f == CP_APOS) ? r_in_word : is_word_base(code_f);
    assign fam     = vowel_family(code_f);

    always_comb begin
        unique case (fam)
            FAM_A:   fam_hot = NUM_FAM'(6'b000001);
            FAM_E:   fam_hot = NUM_FAM'(6'b000010);
            FAM_I:   fam_hot = NUM_FAM'(6'b000100);
            FAM_O:   fam_hot = NUM_FAM'(6'b001000);
            FAM_U:   fam_hot = NUM_FAM'(6'b010000);
            FAM_Y:   fam_hot = NUM_FAM'(6'b100000);
            default: fam_hot = '0;
        endcase
    end

    always_comb begin
        n_words   = r_words;
        n_seen    = r_seen;
        n_in_word = r_in_word;
        for (int k = 0; k < NUM_FAM; k++) begin
            n_vtot[k] = r_vtot[k];
        end
        if (take) begin
            if (i_cp.last) begin
                n_words   = '0;
                n_seen    = '0;
                n_in_word = 1'b0;
                for (int k = 0; k < NUM_FAM; k++) begin
                    n_vtot[k] = '0;
                end
            end else if (is_word) begin
                n_in_word = 1'b1;
                if (!r_in_word) begin
                    n_words = sat_inc(r_words);
                end
                for (int k = 0; k < NUM_FAM; k++) begin
                    if (fam_hot[k] && !r_seen[k]) begin
                        n_vtot[k] = sat_inc(r_vtot[k]);
                        n_seen[k] = 1'b1;
                    end
                end
            end else begin
                n_seen    = '0;
                n_in_word = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_words     <= '0;
            r_seen      <= '0;
            r_in_word   <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < NUM_FAM; k++) begin
                r_vtot[k] <= '0;
            end
        end else begin
            r_words   <= n_words;
            r_seen    <= n_seen;
            r_in_word <= n_in_word;
            for (int k = 0; k < NUM_FAM; k++) begin
                r_vtot[k] <= n_vtot[k];
            end
            if (take && i_cp.last) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_cp.last) begin
            r_res.word_count <= to_out(r_words);
            r_res.a_count    <= to_out(r_vtot[FAM_A]);
            r_res.e_count    <= to_out(r_vtot[FAM_E]);
            r_res.i_count    <= to_out(r_vtot[FAM_I]);
            r_res.o_count    <= to_out(r_vtot[FAM_O]);
            r_res.u_count    <= to_out(r_vtot[FAM_U]);
            r_res.y_count    <= to_out(r_vtot[FAM_Y]);
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_res;

endmodule

/* hdl/utf8_word_vowel_counter.sv */
// Channel  Dir  Payload                              Handshake
// i_in     in   command, data_byte                   valid / ready
// o_out    out  word_count, a_count .. y_count       valid / ready
//
// One input word per cycle unless backpressure holds i_in, as described below.
// An end word passes the input and code point registers into the result register.
// Backpressure reaches i_in only when an end word finds an unread result in
// the output register; data words keep flowing while a result waits.
// i_rst_n (synchronous, active low) clears the decoder, the word state and counts.
module utf8_word_vowel_counter #(
    parameter int COUNT_WIDTH = uwvc_pkg::COUNT_WIDTH_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    uwvc_in_if.sink    i_in,
    uwvc_out_if.source o_out
);
    import uwvc_pkg::*;

    t_cp     cp;
    logic    cp_ready;
    t_result res;

    uwvc_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .o_ready     (i_in.ready),
        .i_command   (i_in.command),
        .i_data_byte (i_in.data_byte),
        .o_cp        (cp),
        .i_cp_ready  (cp_ready)
    );

    uwvc_count #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_count (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cp       (cp),
        .o_cp_ready (cp_ready),
        .o_valid    (o_out.valid),
        .i_ready    (o_out.ready),
        .o_res      (res)
    );

    assign o_out.word_count = res.word_count;
    assign o_out.a_count    = res.a_count;
    assign o_out.e_count    = res.e_count;
    assign o_out.i_count    = res.i_count;
    assign o_out.o_count    = res.o_count;
    assign o_out.u_count    = res.u_count;
    assign o_out.y_count    = res.y_count;

endmodule

/* hdl/uwvc_checker.sv */
`include "utf8_word_vowel_counter_macros.svh"

module uwvc_checker #(
    parameter int COUNT_WIDTH = uwvc_pkg::COUNT_WIDTH_DEF
) (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_out_valid,
    input logic                     i_out_ready,
    input logic [uwvc_pkg::OUT_W-1:0] i_word_count,
    input logic [uwvc_pkg::OUT_W-1:0] i_a_count,
    input logic [uwvc_pkg::OUT_W-1:0] i_e_count,
    input logic [uwvc_pkg::OUT_W-1:0] i_i_count,
    input logic [uwvc_pkg::OUT_W-1:0] i_o_count,
    input logic [uwvc_pkg::OUT_W-1:0] i_u_count,
    input logic [uwvc_pkg::OUT_W-1:0] i_y_count
);
    import uwvc_pkg::*;

    logic [7*OUT_W-1:0] all_counts;
    logic               vowels_le_words;

    assign all_counts = {i_word_count, i_a_count, i_e_count, i_i_count,
                         i_o_count, i_u_count, i_y_count};

    // a word counts at most once per family, so no family total passes the word total
    assign vowels_le_words = (i_a_count <= i_word_count) && (i_e_count <= i_word_count) &&
                             (i_i_count <= i_word_count) && (i_o_count <= i_word_count) &&
                             (i_u_count <= i_word_count) && (i_y_count <= i_word_count);

    `UWVC_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid)

    `UWVC_ASSERT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> $stable(all_counts))

    `UWVC_ASSERT(a_vowel_le_words, i_clk, i_rst_n, (COUNT_WIDTH <= OUT_W) && i_out_valid |-> vowels_le_words)

    `UWVC_ASSERT_ALWAYS(a_rst_clears_out, i_clk, !i_rst_n |=> !i_out_valid)

endmodule

bind utf8_word_vowel_counter uwvc_checker #(
    .COUNT_WIDTH (COUNT_WIDTH)
) u_uwvc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_word_count (o_out.word_count),
    .i_a_count    (o_out.a_count),
    .i_e_count    (o_out.e_count),
    .i_i_count    (o_out.i_count),
    .i_o_count    (o_out.o_count),
    .i_u_count    (o_out.u_count),
    .i_y_count    (o_out.y_count)
);

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
    import uwvc_pkg::*;

    localparam int          CYCLE_LIMIT = 500000;
    localparam logic [31:0] COUNT_MAX   = 32'hFFFF_FFFF;

    logic i_clk;
    logic i_rst_n;

    uwvc_in_if  in_if();
    uwvc_out_if out_if();

    utf8_word_vowel_counter dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // predicted decoder and counter state
    logic [2:0]  tl_pending;
    logic [31:0] tl_accum;
    logic        tl_in_word;
    logic [5:0]  tl_seen;
    logic [31:0] tl_words;
    logic [31:0] tl_family [NUM_FAM];

    t_result expected_tallies[$];

    bit idle_en;
    int hold_cnt;
    int errors;
    int words_accepted;
    int ends_sent;
    int tallies_checked;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == COUNT_MAX) ? v : v + 32'd1;
    endfunction

    function automatic logic [31:0] fold_cp(input logic [31:0] cp);
        logic [31:0] c;
        c = (cp >= 32'hE0) ? cp - 32'h20 : cp;
        if (c == 32'h1FF8 || c == 32'h1FF9) begin
            c = 32'h27;
        end
        return c;
    endfunction

    // letters, digits, underscore, C cedilla and the accented vowels
    function automatic logic is_letter_cp(input logic [31:0] c);
        return c inside {[32'h30:32'h39], [32'h41:32'h5A], [32'h61:32'h7A], 32'h5F,
                         [32'hC0:32'hC3], 32'hC7, [32'hC8:32'hCA], [32'hCC:32'hCD],
                         [32'hD2:32'hD5], [32'hD9:32'hDA]};
    endfunction

    function automatic t_family family_of(input logic [31:0] c);
        if (c inside {32'h41, 32'h61, [32'hC0:32'hC3]}) return FAM_A;
        if (c inside {32'h45, 32'h65, [32'hC8:32'hCA]}) return FAM_E;
        if (c inside {32'h49, 32'h69, [32'hCC:32'hCD]}) return FAM_I;
        if (c inside {32'h4F, 32'h6F, [32'hD2:32'hD5]}) return FAM_O;
        if (c inside {32'h55, 32'h75, [32'hD9:32'hDA]}) return FAM_U;
        if (c inside {32'h59, 32'h79}) return FAM_Y;
        return FAM_NONE;
    endfunction

    function automatic void clear_tally();
        tl_pending = '0;
        tl_accum   = '0;
        tl_in_word = 1'b0;
        tl_seen    = '0;
        tl_words   = '0;
        for (int k = 0; k < NUM_FAM; k++) tl_family[k] = '0;
    endfunction

    function automatic void take_code_point(input logic [31:0] cp);
        logic [31:0] c;
        logic        is_word;
        t_family     f;
        c = fold_cp(cp);
        // an apostrophe only belongs to a word that is already open
        is_word = (c == 32'h27) ? tl_in_word : is_letter_cp(c);
        if (is_word) begin
            if (!tl_in_word) begin
                tl_in_word = 1'b1;
                tl_words   = sat_inc(tl_words);
            end
            f = family_of(c);
            if (f != FAM_NONE && !tl_seen[int'(f)]) begin
                tl_family[int'(f)] = sat_inc(tl_family[int'(f)]);
                tl_seen[int'(f)]   = 1'b1;
            end
        end else begin
            tl_seen    = '0;
            tl_in_word = 1'b0;
        end
    endfunction

    function automatic void advance_tally(input t_cmd cmd, input logic [7:0] b);
        t_result     r;
        int          lead;
        logic [31:0] payload;
        if (cmd == CMD_END) begin
            r.word_count = tl_words;
            r.a_count    = tl_family[int'(FAM_A)];
            r.e_count    = tl_family[int'(FAM_E)];
            r.i_count    = tl_family[int'(FAM_I)];
            r.o_count    = tl_family[int'(FAM_O)];
            r.u_count    = tl_family[int'(FAM_U)];
            r.y_count    = tl_family[int'(FAM_Y)];
            expected_tallies.push_back(r);
            clear_tally();
        end else if (tl_pending != 0) begin
            // anything inside an open sequence is a continuation
            tl_accum   = {tl_accum[25:0], b[5:0]};
            tl_pending = tl_pending - 3'd1;
            if (tl_pending == 0) take_code_point(tl_accum);
        end else if (!b[7]) begin
            take_code_point({24'h0, b});
        end else begin
            lead = 1;
            while (lead < 8 && b[7 - lead]) lead++;
            payload = (lead >= 7) ? 32'h0 : 32'(b & ((8'h1 << (7 - lead)) - 8'h1));
            if (lead <= 1) begin
                take_code_point(payload);
            end else begin
                tl_accum   = payload;
                tl_pending = 3'(lead - 1);
            end
        end
    endfunction

    task automatic send_word(input t_cmd cmd, input logic [7:0] b);
        int gap;
        if (idle_en && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 19);
            @(negedge i_clk);
            in_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_if.valid     <= 1'b1;
        in_if.command   <= cmd;
        in_if.data_byte <= b;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        advance_tally(cmd, b);
        words_accepted++;
        if (cmd == CMD_END) ends_sent++;
    endtask

    task automatic send_code_point(input logic [20:0] cp);
        if (cp < 21'h80) begin
            send_word(CMD_DATA, cp[7:0]);
        end else if (cp < 21'h800) begin
            send_word(CMD_DATA, {3'b110, cp[10:6]});
            send_word(CMD_DATA, {2'b10, cp[5:0]});
        end else if (cp < 21'h10000) begin
            send_word(CMD_DATA, {4'b1110, cp[15:12]});
            send_word(CMD_DATA, {2'b10, cp[11:6]});
            send_word(CMD_DATA, {2'b10, cp[5:0]});
        end else begin
            send_word(CMD_DATA, {5'b11110, cp[20:18]});
            send_word(CMD_DATA, {2'b10, cp[17:12]});
            send_word(CMD_DATA, {2'b10, cp[11:6]});
            send_word(CMD_DATA, {2'b10, cp[5:0]});
        end
    endtask

    function automatic logic [20:0] pick_code_point();
        logic [7:0] vowels [12];
        int         sel;
        vowels = '{8'h41, 8'h45, 8'h49, 8'h4F, 8'h55, 8'h59,
                   8'h61, 8'h65, 8'h69, 8'h6F, 8'h75, 8'h79};
        sel = $urandom_range(0, 99);
        if (sel < 28) return 21'(vowels[$urandom_range(0, 11)]);
        if (sel < 38) return 21'($urandom_range(8'h41, 8'h5A));
        if (sel < 46) return 21'($urandom_range(8'h61, 8'h7A));
        if (sel < 50) return ($urandom_range(0, 1) != 0) ? 21'h5F : 21'($urandom_range(8'h30, 8'h39));
        if (sel < 62) return 21'($urandom_range(8'h00, 8'h2F));
        if (sel < 67) return 21'h27;
        if (sel < 72) return ($urandom_range(0, 1) != 0) ? 21'h2018 : 21'h2019;
        if (sel < 85) return 21'($urandom_range(8'hC0, 8'hFF));
        if (sel < 91) return 21'($urandom_range(12'h080, 12'h7FF));
        if (sel < 97) return 21'($urandom_range(16'h0800, 16'hFFFF));
        return 21'($urandom_range(21'h10000, 21'h10FFFF));
    endfunction

    // mostly well-formed text, some raw bytes and over-long leads, then an end word
    task automatic send_text_segment(input int n_cp);
        int sel;
        for (int k = 0; k < n_cp; k++) begin
            sel = $urandom_range(0, 29);
            if (sel == 0) begin
                send_word(CMD_DATA, 8'($urandom_range(8'hF8, 8'hFF)));
                repeat ($urandom_range(1, 8)) send_word(CMD_DATA, 8'($urandom_range(8'h80, 8'hBF)));
            end else if (sel < 3) begin
                send_word(CMD_DATA, 8'($urandom_range(0, 255)));
            end else begin
                send_code_point(pick_code_point());
            end
        end
        send_word(CMD_END, 8'($urandom_range(0, 255)));
    endtask

    task automatic test_vowel_families();
        // "aE'y" then a stray apostrophe outside a word, then "O9"
        send_word(CMD_DATA, 8'h61);
        send_word(CMD_DATA, 8'h45);
        send_word(CMD_DATA, 8'h27);
        send_word(CMD_DATA, 8'h79);
        send_word(CMD_DATA, 8'h20);
        send_word(CMD_DATA, 8'h27);
        send_word(CMD_DATA, 8'h4F);
        send_word(CMD_DATA, 8'h39);
        send_word(CMD_DATA, 8'h00);
    endtask

    task automatic test_multibyte_sequences();
        // lower e acute folds to upper, right curly quote acts as apostrophe
        send_word(CMD_DATA, 8'hC3);
        send_word(CMD_DATA, 8'hA9);
        send_word(CMD_DATA, 8'hE2);
        send_word(CMD_DATA, 8'h80);
        send_word(CMD_DATA, 8'h99);
        // lone continuation breaks the word
        send_word(CMD_DATA, 8'h9A);
        // six continuations, top bits fall off the 32-bit accumulator leaving 'A'
        send_word(CMD_DATA, 8'hFE);
        send_word(CMD_DATA, 8'hBC);
        send_word(CMD_DATA, 8'h80);
        send_word(CMD_DATA, 8'h80);
        send_word(CMD_DATA, 8'h80);
        send_word(CMD_DATA, 8'h81);
        send_word(CMD_DATA, 8'h81);
        send_word(CMD_DATA, 8'h5F);
    endtask

    task automatic test_end_of_text();
        send_word(CMD_DATA, 8'hC3);
        send_word(CMD_END, 8'hFF);
        send_word(CMD_END, 8'h00);
        send_word(CMD_DATA, 8'hFF);
        send_word(CMD_END, 8'hA5);
    endtask

    task automatic test_random_text();
        while (words_accepted < 1300 || ends_sent < 30) begin
            send_text_segment($urandom_range(4, 50));
        end
    endtask

    task automatic test_output_backpressure();
        hold_cnt = 300;
        repeat (6) send_text_segment($urandom_range(2, 6));
    endtask

    task automatic test_full_rate();
        idle_en = 1'b0;
        repeat (5) send_text_segment($urandom_range(5, 20));
    endtask

    // result sink: long hold-off when requested, else random stall bursts (idle_en)
    initial begin
        int stall;
        stall = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cnt > 0) begin
                hold_cnt--;
                out_if.ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                out_if.ready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 19) - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_result     want;
        logic [31:0] got_v [7];
        logic [31:0] want_v [7];
        string       names [7];
        names = '{"word_count", "a_count", "e_count", "i_count", "o_count", "u_count",
                  "y_count"};
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_tallies.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("unexpected result word, word_count %0d", out_if.word_count);
                end
            end else begin
                want   = expected_tallies.pop_front();
                got_v  = '{out_if.word_count, out_if.a_count, out_if.e_count, out_if.i_count,
                           out_if.o_count, out_if.u_count, out_if.y_count};
                want_v = '{want.word_count, want.a_count, want.e_count, want.i_count,
                           want.o_count, want.u_count, want.y_count};
                for (int k = 0; k < 7; k++) begin
                    if (got_v[k] !== want_v[k]) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("result %0d %s: expected %0d got %0d",
                                     tallies_checked, names[k], want_v[k], got_v[k]);
                        end
                    end
                end
                tallies_checked++;
            end
        end
    end

    initial begin
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        in_if.valid     = 1'b0;
        in_if.command   = CMD_DATA;
        in_if.data_byte = '0;
        i_rst_n         = 1'b0;
        idle_en         = 1'b1;
        hold_cnt        = 0;
        errors          = 0;
        words_accepted  = 0;
        ends_sent       = 0;
        tallies_checked = 0;
        clear_tally();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_vowel_families();
        test_multibyte_sequences();
        test_end_of_text();
        test_random_text();
        test_output_backpressure();
        test_full_rate();

        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (expected_tallies.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
